// ===== rtl/bkg_pkg.sv =====
package bkg_pkg;

  localparam int MAX_GROUP  = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(MAX_GROUP);
  localparam int CNT_W      = $clog2(MAX_GROUP + 1);
  localparam int CFG_W      = 5;

  localparam logic [CFG_W-1:0] GROUP_SIZE_RST = CFG_W'(2);

  typedef struct packed {
    logic             wr_en;
    logic             clr_fill;
    logic             ld_out;
    logic [IDX_W-1:0] rd_idx;
    logic             run_last;
    logic             list_end;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] fill;
    logic             out_free;
  } status_t;

endpackage

// ===== rtl/block_reverse_k_group_core.sv =====
// Group reverser for a streamed list of signed values.
// Input channel (in_valid/in_ready): one element per request with in_list_end
// on the final element of the list. Config channel (cfg_valid/cfg_ready,
// always ready): cfg_data sets the group size; 0 and 1 pass elements through,
// sizes above 16 act as 16. Write it only while the block is idle.
// Result channel (out_valid/out_ready): elements of a full group come out in
// reverse order; a partial group at list end comes out in arrival order.
// out_run_last marks the last element of each run, out_list_end the final
// element of the list.
// Timing: an element that does not close a run leaves the input ready. An
// element that closes a run of n elements blocks the input while the
// controller reads the group store one entry per cycle whenever the output
// register is free; the first result is loaded only after the controller has
// entered its drain state. The output register lets the next input request
// in while the final result of a run still waits.
// A receiver stall holds the output register and pauses the drain.
// Reset (rst_n low, synchronous) empties the group and sets the size to 2.
module block_reverse_k_group_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bkg_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [bkg_pkg::DATA_WIDTH-1:0] in_elem_value,
  input  logic                                  in_list_end,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [bkg_pkg::DATA_WIDTH-1:0] out_value,
  output logic                                  out_run_last,
  output logic                                  out_list_end
);

  bkg_pkg::cmd_t    cmd;
  bkg_pkg::status_t sts;

  bkg_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_list_end (in_list_end),
    .sts         (sts),
    .cmd         (cmd)
  );

  bkg_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_elem_value (in_elem_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value),
    .out_run_last  (out_run_last),
    .out_list_end  (out_list_end)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sts.fill <= bkg_pkg::CNT_W'(bkg_pkg::MAX_GROUP))
    else $error("group fill beyond capacity");

  a_end_drains: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_list_end |=> !in_ready)
    else $error("list end did not start a drain");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_list_end |-> out_run_last)
    else $error("list end without run end");

  a_clr_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_fill |-> cmd.ld_out && cmd.run_last && !cmd.wr_en)
    else $error("group cleared outside run end");

endmodule

// ===== rtl/bkg_datapath.sv =====
module bkg_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  bkg_pkg::cmd_t                         cmd,
  output bkg_pkg::status_t                      sts,
  input  logic signed [bkg_pkg::DATA_WIDTH-1:0] in_elem_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [bkg_pkg::DATA_WIDTH-1:0] out_value,
  output logic                                  out_run_last,
  output logic                                  out_list_end
);

  logic [bkg_pkg::DATA_WIDTH-1:0] store_r [bkg_pkg::MAX_GROUP];
  logic [bkg_pkg::CNT_W-1:0]      fill_r;
  logic                           has_room;
  logic                           out_valid_r;
  logic [bkg_pkg::DATA_WIDTH-1:0] out_value_r;
  logic                           run_last_r;
  logic                           list_end_r;

  assign has_room = fill_r < bkg_pkg::CNT_W'(bkg_pkg::MAX_GROUP);

  always_ff @(posedge clk) begin
    if (cmd.wr_en && has_room) begin
      store_r[fill_r[bkg_pkg::IDX_W-1:0]] <= in_elem_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_fill) begin
        fill_r <= '0;
      end else if (cmd.wr_en && has_room) begin
        fill_r <= fill_r + bkg_pkg::CNT_W'(1);
      end
      if (cmd.ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_value_r <= store_r[cmd.rd_idx];
      run_last_r  <= cmd.run_last;
      list_end_r  <= cmd.list_end;
    end
  end

  assign sts.fill     = fill_r;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_run_last = run_last_r;
  assign out_list_end = list_end_r;

endmodule

// ===== rtl/bkg_ctrl.sv =====
module bkg_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bkg_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_list_end,
  input  bkg_pkg::status_t             sts,
  output bkg_pkg::cmd_t                cmd
);

  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } state_t;

  state_t                    state_r, state_nxt;
  logic [bkg_pkg::CFG_W-1:0] grp_r, grp_nxt;
  logic [bkg_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic [bkg_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      rev_r, rev_nxt;
  logic                      last_r, last_nxt;

  logic [bkg_pkg::CNT_W-1:0] k_eff;
  logic [bkg_pkg::CNT_W-1:0] fill_inc;
  logic [bkg_pkg::CNT_W-1:0] rev_idx;
  logic                      in_fire;
  logic                      full_grp;
  logic                      at_end;

  always_comb begin
    if (grp_r <= bkg_pkg::CFG_W'(1)) begin
      k_eff = bkg_pkg::CNT_W'(1);
    end else if (32'(grp_r) > bkg_pkg::MAX_GROUP) begin
      k_eff = bkg_pkg::CNT_W'(bkg_pkg::MAX_GROUP);
    end else begin
      k_eff = bkg_pkg::CNT_W'(grp_r);
    end
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign fill_inc  = (sts.fill < bkg_pkg::CNT_W'(bkg_pkg::MAX_GROUP))
                     ? sts.fill + bkg_pkg::CNT_W'(1) : sts.fill;
  assign full_grp  = fill_inc >= k_eff;
  assign at_end    = idx_r == cnt_r - bkg_pkg::CNT_W'(1);
  assign rev_idx   = rev_r ? (cnt_r - bkg_pkg::CNT_W'(1) - idx_r) : idx_r;

  always_comb begin
    cmd.wr_en    = in_fire;
    cmd.ld_out   = (state_r == S_DRAIN) && sts.out_free;
    cmd.rd_idx   = rev_idx[bkg_pkg::IDX_W-1:0];
    cmd.run_last = at_end;
    cmd.list_end = at_end && last_r;
    cmd.clr_fill = cmd.ld_out && at_end;
  end

  always_comb begin
    state_nxt = state_r;
    grp_nxt   = grp_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    rev_nxt   = rev_r;
    last_nxt  = last_r;
    if (cfg_valid && cfg_ready) begin
      grp_nxt = cfg_data;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (full_grp || in_list_end)) begin
          state_nxt = S_DRAIN;
          idx_nxt   = '0;
          cnt_nxt   = fill_inc;
          rev_nxt   = full_grp;
          last_nxt  = in_list_end;
        end
      end
      S_DRAIN: begin
        if (cmd.ld_out) begin
          if (at_end) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + bkg_pkg::CNT_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      grp_r   <= bkg_pkg::GROUP_SIZE_RST;
      idx_r   <= '0;
      cnt_r   <= '0;
      rev_r   <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      grp_r   <= grp_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      rev_r   <= rev_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

// ===== bench/block_reverse_k_group_core_tb.sv =====
module block_reverse_k_group_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 2 * bkg_pkg::MAX_GROUP + 8;
  localparam int QUIET_LIMIT  = 3000;
  localparam int LONG_HOLD    = 400;
  localparam int ITEM_TARGET  = 450;

  typedef struct {
    logic signed [bkg_pkg::DATA_WIDTH-1:0] value;
    logic                                  run_last;
    logic                                  list_end;
  } grp_result_t;

  typedef enum {ROW_CFG, ROW_ELEM} row_kind_t;

  typedef struct {
    row_kind_t                             kind;
    logic [bkg_pkg::CFG_W-1:0]             size;
    logic signed [bkg_pkg::DATA_WIDTH-1:0] value;
    logic                                  last;
    int                                    typed_n;
    logic signed [bkg_pkg::DATA_WIDTH-1:0] t0;
    logic signed [bkg_pkg::DATA_WIDTH-1:0] t1;
    logic                                  t_le;
  } stim_row_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

  logic                                  clk = 1'b0;
  logic                                  rst_n = 1'b0;
  logic                                  cfg_valid = 1'b0;
  logic                                  cfg_ready;
  logic [bkg_pkg::CFG_W-1:0]             cfg_data = '0;
  logic                                  in_valid = 1'b0;
  logic                                  in_ready;
  logic signed [bkg_pkg::DATA_WIDTH-1:0] in_elem_value = '0;
  logic                                  in_list_end = 1'b0;
  logic                                  out_valid;
  logic                                  out_ready = 1'b0;
  logic signed [bkg_pkg::DATA_WIDTH-1:0] out_value;
  logic                                  out_run_last;
  logic                                  out_list_end;

  block_reverse_k_group_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_elem_value(in_elem_value),
    .in_list_end  (in_list_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_run_last (out_run_last),
    .out_list_end (out_list_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [bkg_pkg::DATA_WIDTH-1:0] held_elems [bkg_pkg::MAX_GROUP];
  int                                    held_n = 0;
  logic [bkg_pkg::CFG_W-1:0]             group_size = bkg_pkg::GROUP_SIZE_RST;
  grp_result_t                           run_buf [bkg_pkg::MAX_GROUP];
  int                                    run_n;

  grp_result_t                           pending_results [$];
  stim_row_t                             directed_rows [$];
  int                                    errors = 0;
  int                                    sent = 0;
  int                                    burst_left = 0;

  int                                    hold_ask = 0;
  int                                    hold_seen = 0;
  int                                    hold_left = 0;
  rx_mode_t                              rx_mode = RX_OPEN;
  int                                    rx_mode_left = 0;
  int                                    quiet = 0;

  function automatic int eff_size(input logic [bkg_pkg::CFG_W-1:0] k);
    if (k < 1) return 1;
    if (k > bkg_pkg::MAX_GROUP) return bkg_pkg::MAX_GROUP;
    return int'(k);
  endfunction

  function automatic void reorder_step(input logic signed [bkg_pkg::DATA_WIDTH-1:0] v,
                                       input logic last);
    int  k;
    int  n;
    int  src;
    bit  rev;
    k = eff_size(group_size);
    if (held_n < bkg_pkg::MAX_GROUP) begin
      held_elems[held_n] = v;
      held_n++;
    end
    run_n = 0;
    if (held_n >= k) rev = 1'b1;
    else if (last) rev = 1'b0;
    else return;
    n = held_n;
    for (int i = 0; i < n; i++) begin
      src = rev ? (n - 1 - i) : i;
      run_buf[i].value    = held_elems[src];
      run_buf[i].run_last = (i == n - 1);
      run_buf[i].list_end = last && (i == n - 1);
    end
    run_n  = n;
    held_n = 0;
  endfunction

  function automatic logic signed [bkg_pkg::DATA_WIDTH-1:0] rand_value();
    case ($urandom_range(7, 0))
      0: return $urandom_range(1, 0) ? 32'sh7FFFFFFF : 32'sh80000000;
      1: return $urandom_range(1, 0) ? 32'sd0 : -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [bkg_pkg::CFG_W-1:0] rand_group_size();
    int r;
    r = $urandom_range(99, 0);
    if (r < 8) return '0;
    if (r < 16) return bkg_pkg::CFG_W'(1);
    if (r < 70) return bkg_pkg::CFG_W'($urandom_range(6, 2));
    if (r < 92) return bkg_pkg::CFG_W'($urandom_range(16, 7));
    return bkg_pkg::CFG_W'($urandom_range(31, 17));
  endfunction

  function automatic void add_cfg(input logic [bkg_pkg::CFG_W-1:0] k);
    stim_row_t r;
    r = '{ROW_CFG, k, 0, 1'b0, -1, 0, 0, 1'b0};
    directed_rows.push_back(r);
  endfunction

  function automatic void add_elem(input logic signed [bkg_pkg::DATA_WIDTH-1:0] v,
                                   input logic l, input int tn,
                                   input logic signed [bkg_pkg::DATA_WIDTH-1:0] t0,
                                   input logic signed [bkg_pkg::DATA_WIDTH-1:0] t1,
                                   input logic tle);
    stim_row_t r;
    r = '{ROW_ELEM, '0, v, l, tn, t0, t1, tle};
    directed_rows.push_back(r);
  endfunction

  task automatic note_mismatch(input string msg);
    if (errors < 40) $display("mismatch: %s", msg);
    errors++;
  endtask

  task automatic offer_elem(input logic signed [bkg_pkg::DATA_WIDTH-1:0] v,
                            input logic l);
    in_valid      <= 1'b1;
    in_elem_value <= v;
    in_list_end   <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // typed_n below zero: take the expectation from the predictor
  task automatic deliver(input logic signed [bkg_pkg::DATA_WIDTH-1:0] v, input logic l,
                         input int typed_n,
                         input logic signed [bkg_pkg::DATA_WIDTH-1:0] t0,
                         input logic signed [bkg_pkg::DATA_WIDTH-1:0] t1,
                         input logic t_le);
    int          gap;
    grp_result_t r;
    offer_elem(v, l);
    sent++;
    reorder_step(v, l);
    if (typed_n < 0) begin
      for (int i = 0; i < run_n; i++) pending_results.push_back(run_buf[i]);
    end else begin
      for (int i = 0; i < typed_n; i++) begin
        r.value    = (i == 0) ? t0 : t1;
        r.run_last = (i == typed_n - 1);
        r.list_end = t_le && (i == typed_n - 1);
        pending_results.push_back(r);
      end
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_group_size(input logic [bkg_pkg::CFG_W-1:0] k);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    group_size  = k;
  endtask

  always @(posedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_t'($urandom_range(2, 0));
        rx_mode_left <= $urandom_range(80, 10);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN: out_ready <= 1'b1;
        RX_COIN: out_ready <= ($urandom_range(1, 0) == 1);
        default: out_ready <= ($urandom_range(3, 0) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    grp_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result value %0d", out_value));
      end else begin
        want = pending_results.pop_front();
        if (out_value !== want.value)
          note_mismatch($sformatf("out_value got %0d want %0d", out_value, want.value));
        if (out_run_last !== want.run_last)
          note_mismatch($sformatf("out_run_last got %b want %b", out_run_last, want.run_last));
        if (out_list_end !== want.list_end)
          note_mismatch($sformatf("out_list_end got %b want %b", out_list_end, want.list_end));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int                        lists;
    int                        len;
    int                        cut;
    int                        phase;
    logic [bkg_pkg::CFG_W-1:0] k;

    add_elem(32'sh7FFFFFFF, 1'b0, 0, 0, 0, 1'b0);
    add_elem(32'sh80000000, 1'b0, 2, 32'sh80000000, 32'sh7FFFFFFF, 1'b0);
    add_elem(-32'sd1, 1'b1, 1, -32'sd1, 0, 1'b1);
    add_cfg(1);
    add_elem(32'sd0, 1'b0, 1, 32'sd0, 0, 1'b0);
    add_elem(32'sh55555555, 1'b1, 1, 32'sh55555555, 0, 1'b1);
    add_cfg(0);
    add_elem(32'shAAAAAAAA, 1'b0, 1, 32'shAAAAAAAA, 0, 1'b0);
    add_cfg(31);
    for (int i = 0; i < bkg_pkg::MAX_GROUP; i++)
      add_elem(32'(i * 32'h01010101 - 8), i == bkg_pkg::MAX_GROUP - 1, -1, 0, 0, 1'b0);
    add_cfg(3);
    add_elem(32'sd11, 1'b0, -1, 0, 0, 1'b0);
    add_elem(-32'sd22, 1'b0, -1, 0, 0, 1'b0);
    add_cfg(2);
    add_elem(32'sd33, 1'b1, -1, 0, 0, 1'b0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_group_size(directed_rows[i].size);
      else
        deliver(directed_rows[i].value, directed_rows[i].last, directed_rows[i].typed_n,
                directed_rows[i].t0, directed_rows[i].t1, directed_rows[i].t_le);
    end

    phase = 0;
    while (sent < ITEM_TARGET) begin
      write_group_size(rand_group_size());
      if (phase == 2) hold_ask <= hold_ask + 1;
      lists = $urandom_range(3, 1);
      for (int li = 0; li < lists && sent < ITEM_TARGET; li++) begin
        len = $urandom_range(3 * eff_size(group_size) + 1, 1);
        cut = ($urandom_range(5, 0) == 0) ? $urandom_range(len - 1, 0) : -1;
        for (int e = 0; e < len; e++) begin
          if (e == cut && e > 0) begin
            k = rand_group_size();
            write_group_size(k);
          end
          deliver(rand_value(), e == len - 1, -1, 0, 0, 1'b0);
        end
      end
      phase++;
    end

    wait_drained();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bkg_pkg.sv
rtl/bkg_datapath.sv
rtl/bkg_ctrl.sv
rtl/block_reverse_k_group_core.sv
bench/block_reverse_k_group_core_tb.sv
